// ===== rtl/core/a64bsd_pkg.sv =====
// Package with codes, encoding masks and the result record of the AArch64 branch/system decoder.
package a64bsd_pkg;

  // Result status of one decoded word.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNSUP   = 2'd1,
    ST_UNALLOC = 2'd2
  } status_t;

  // Instruction codes in the order of the recognized forms.
  typedef enum logic [4:0] {
    CODE_NONE    = 5'd0,
    CODE_B       = 5'd1,
    CODE_BL      = 5'd2,
    CODE_CBZ     = 5'd3,
    CODE_CBNZ    = 5'd4,
    CODE_TBZ     = 5'd5,
    CODE_TBNZ    = 5'd6,
    CODE_BCOND   = 5'd7,
    CODE_SVC     = 5'd8,
    CODE_HVC     = 5'd9,
    CODE_SMC     = 5'd10,
    CODE_BRK     = 5'd11,
    CODE_HLT     = 5'd12,
    CODE_NOP     = 5'd13,
    CODE_YIELD   = 5'd14,
    CODE_WFE     = 5'd15,
    CODE_WFI     = 5'd16,
    CODE_SEV     = 5'd17,
    CODE_SEVL    = 5'd18,
    CODE_PACIASP = 5'd19,
    CODE_BTI     = 5'd20,
    CODE_CLREX   = 5'd21,
    CODE_DSB     = 5'd22,
    CODE_DMB     = 5'd23,
    CODE_ISB     = 5'd24,
    CODE_MSR     = 5'd25,
    CODE_MRS     = 5'd26,
    CODE_BR      = 5'd27,
    CODE_BLR     = 5'd28,
    CODE_RET     = 5'd29,
    CODE_ERET    = 5'd30,
    CODE_DRPS    = 5'd31
  } code_t;

  // Encoding masks and match values.
  localparam logic [31:0] MASK_BCOND   = 32'hFF00_0010;
  localparam logic [31:0] MATCH_BCOND  = 32'h5400_0000;
  localparam logic [31:0] MASK_EXC     = 32'hFFE0_001F;
  localparam logic [31:0] MATCH_SVC    = 32'hD400_0001;
  localparam logic [31:0] MATCH_HVC    = 32'hD400_0002;
  localparam logic [31:0] MATCH_SMC    = 32'hD400_0003;
  localparam logic [31:0] MATCH_BRK    = 32'hD420_0000;
  localparam logic [31:0] MATCH_HLT    = 32'hD440_0000;
  localparam logic [31:0] MASK_HINT    = 32'hFFFF_F01F;
  localparam logic [31:0] MATCH_HINT   = 32'hD503_201F;
  localparam logic [31:0] MASK_BARRIER = 32'hFFFF_F0FF;
  localparam logic [31:0] MATCH_CLREX  = 32'hD503_305F;
  localparam logic [31:0] MATCH_DSB    = 32'hD503_309F;
  localparam logic [31:0] MATCH_DMB    = 32'hD503_30BF;
  localparam logic [31:0] MATCH_ISB    = 32'hD503_30DF;
  localparam logic [31:0] MASK_SYSMOVE = 32'hFFF0_0000;
  localparam logic [31:0] MATCH_MSR    = 32'hD510_0000;
  localparam logic [31:0] MATCH_MRS    = 32'hD530_0000;
  localparam logic [31:0] MASK_BRREG   = 32'hFFFF_FC1F;
  localparam logic [31:0] MATCH_BR     = 32'hD61F_0000;
  localparam logic [31:0] MATCH_BLR    = 32'hD63F_0000;
  localparam logic [31:0] MATCH_RET    = 32'hD65F_0000;
  localparam logic [31:0] WORD_ERET    = 32'hD69F_03E0;
  localparam logic [31:0] WORD_DRPS    = 32'hD6BF_03E0;

  // Major opcode byte values.
  localparam logic [7:0] TOP_BCOND = 8'h54;
  localparam logic [7:0] TOP_EXC   = 8'hD4;
  localparam logic [7:0] TOP_SYS   = 8'hD5;
  localparam logic [7:0] TOP_BRREG = 8'hD6;

  // Bits 30..26 (B/BL) or 30..25 (compare and test branches) of the word for the immediate branch groups.
  localparam logic [4:0] GRP_B  = 5'b00101;
  localparam logic [5:0] GRP_CB = 6'b011010;
  localparam logic [5:0] GRP_TB = 6'b011011;

  // Full barrier option of ISB.
  localparam logic [3:0] ISB_SY = 4'hF;

  // One decoded result.
  typedef struct packed {
    status_t            status;
    code_t              code;
    logic signed [27:0] branch_offset;
    logic               is_64bit;
    logic [4:0]         target_reg;
    logic [4:0]         base_reg;
    logic [15:0]        imm_value;
    logic [3:0]         cond_code;
    logic [15:0]        sysreg_id;
  } result_t;

endpackage

// ===== rtl/core/arm64_branch_system_decoder_core.sv =====
// Top level of the AArch64 branch, exception and system group decoder.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    in_instruction_word (32)
//   out_     output     out_valid/out_stall  status, code, offset and operand fields
//
// A request is held in the input register, decoded, and loaded into the result
// register when that register is empty or drained; one request is taken every cycle
// unless in_stall is high. The input register's decode is the only logic between them.
// Reset (rst_n low, synchronous) empties both stages. A stall on the output
// holds the result register and lets the input register fill before in_stall rises.
module arm64_branch_system_decoder_core import a64bsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_instruction_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [4:0]         out_instruction_code,
  output logic signed [27:0] out_branch_offset,
  output logic               out_is_64bit,
  output logic [4:0]         out_target_reg,
  output logic [4:0]         out_base_reg,
  output logic [15:0]        out_imm_value,
  output logic [3:0]         out_cond_code,
  output logic [15:0]        out_sysreg_id
);

  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;
  logic        s2_load;
  logic        s1_load;
  logic [31:0] w;
  logic [7:0]  top;
  logic [6:0]  hint;

  // Stage advance: the result register loads when empty or drained.
  assign s2_load  = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = !s1_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load && in_valid) begin
      s1_word_r <= in_instruction_word;
    end
  end

  assign w    = s1_word_r;
  assign top  = w[31:24];
  assign hint = w[11:5];

  // Decode of the registered word.
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = ST_UNSUP;
    res_nxt.code   = CODE_NONE;
    if (w[30:26] == GRP_B) begin
      res_nxt.status        = ST_OK;
      res_nxt.code          = w[31] ? CODE_BL : CODE_B;
      res_nxt.branch_offset = {w[25:0], 2'b00};
    end else if (w[30:25] == GRP_CB) begin
      res_nxt.status        = ST_OK;
      res_nxt.code          = w[24] ? CODE_CBNZ : CODE_CBZ;
      res_nxt.is_64bit      = w[31];
      res_nxt.target_reg    = w[4:0];
      res_nxt.branch_offset = {{7{w[23]}}, w[23:5], 2'b00};
    end else if (w[30:25] == GRP_TB) begin
      res_nxt.status        = ST_OK;
      res_nxt.code          = w[24] ? CODE_TBNZ : CODE_TBZ;
      res_nxt.is_64bit      = w[31];
      res_nxt.target_reg    = w[4:0];
      res_nxt.imm_value     = {10'd0, w[31], w[23:19]};
      res_nxt.branch_offset = {{12{w[18]}}, w[18:5], 2'b00};
    end else if (top == TOP_BCOND) begin
      if ((w & MASK_BCOND) == MATCH_BCOND) begin
        res_nxt.status        = ST_OK;
        res_nxt.code          = CODE_BCOND;
        res_nxt.cond_code     = w[3:0];
        res_nxt.branch_offset = {{7{w[23]}}, w[23:5], 2'b00};
      end
    end else if (top == TOP_EXC) begin
      res_nxt.imm_value = w[20:5];
      case (w & MASK_EXC)
        MATCH_SVC: res_nxt.code = CODE_SVC;
        MATCH_HVC: res_nxt.code = CODE_HVC;
        MATCH_SMC: res_nxt.code = CODE_SMC;
        MATCH_BRK: res_nxt.code = CODE_BRK;
        MATCH_HLT: res_nxt.code = CODE_HLT;
        default:   res_nxt.code = CODE_NONE;
      endcase
      if (res_nxt.code != CODE_NONE) begin
        res_nxt.status = ST_OK;
      end else begin
        res_nxt.imm_value = '0;
      end
    end else if (top == TOP_SYS) begin
      if ((w & MASK_HINT) == MATCH_HINT) begin
        case (hint) inside
          [7'h00:7'h05]: begin
            res_nxt.status = ST_OK;
            res_nxt.code   = code_t'(5'(CODE_NOP) + {2'b00, hint[2:0]});
          end
          7'h19: begin
            res_nxt.status = ST_OK;
            res_nxt.code   = CODE_PACIASP;
          end
          7'h20, 7'h22, 7'h24, 7'h26: begin
            res_nxt.status    = ST_OK;
            res_nxt.code      = CODE_BTI;
            res_nxt.imm_value = {13'd0, hint[2:0]};
          end
          default: begin
            res_nxt.status = ST_UNSUP;
          end
        endcase
      end else if ((w & MASK_BARRIER) == MATCH_CLREX) begin
        res_nxt.status    = ST_OK;
        res_nxt.code      = CODE_CLREX;
        res_nxt.imm_value = {12'd0, w[11:8]};
      end else if ((w & MASK_BARRIER) == MATCH_DSB) begin
        res_nxt.status    = ST_OK;
        res_nxt.code      = CODE_DSB;
        res_nxt.imm_value = {12'd0, w[11:8]};
      end else if ((w & MASK_BARRIER) == MATCH_DMB) begin
        res_nxt.status    = ST_OK;
        res_nxt.code      = CODE_DMB;
        res_nxt.imm_value = {12'd0, w[11:8]};
      end else if ((w & MASK_BARRIER) == MATCH_ISB) begin
        // Only the full-system option is allocated for ISB.
        res_nxt.imm_value = {12'd0, w[11:8]};
        if (w[11:8] == ISB_SY) begin
          res_nxt.status = ST_OK;
          res_nxt.code   = CODE_ISB;
        end else begin
          res_nxt.status = ST_UNALLOC;
        end
      end else if ((w & MASK_SYSMOVE) == MATCH_MSR || (w & MASK_SYSMOVE) == MATCH_MRS) begin
        res_nxt.status     = ST_OK;
        res_nxt.code       = ((w & MASK_SYSMOVE) == MATCH_MSR) ? CODE_MSR : CODE_MRS;
        res_nxt.target_reg = w[4:0];
        res_nxt.sysreg_id  = w[20:5];
        res_nxt.is_64bit   = 1'b1;
      end
    end else if (top == TOP_BRREG) begin
      if ((w & MASK_BRREG) == MATCH_BR || (w & MASK_BRREG) == MATCH_BLR ||
          (w & MASK_BRREG) == MATCH_RET) begin
        res_nxt.status   = ST_OK;
        res_nxt.code     = ((w & MASK_BRREG) == MATCH_BR)  ? CODE_BR  :
                           ((w & MASK_BRREG) == MATCH_BLR) ? CODE_BLR : CODE_RET;
        res_nxt.base_reg = w[9:5];
        res_nxt.is_64bit = 1'b1;
      end else if (w == WORD_ERET) begin
        res_nxt.status = ST_OK;
        res_nxt.code   = CODE_ERET;
      end else if (w == WORD_DRPS) begin
        res_nxt.status = ST_OK;
        res_nxt.code   = CODE_DRPS;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
    if (s2_load && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_instruction_code = res_r.code;
  assign out_branch_offset    = res_r.branch_offset;
  assign out_is_64bit         = res_r.is_64bit;
  assign out_target_reg       = res_r.target_reg;
  assign out_base_reg         = res_r.base_reg;
  assign out_imm_value        = res_r.imm_value;
  assign out_cond_code        = res_r.cond_code;
  assign out_sysreg_id        = res_r.sysreg_id;

`ifndef SYNTHESIS
  // A held input request keeps its word while the result side is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_word_r))
    else $error("input register lost a held request");

  // An unallocated result never carries an instruction code.
  a_unalloc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == ST_UNALLOC |-> res_r.code == CODE_NONE)
    else $error("unallocated result with a code");

  // An unsupported result is all zero apart from its status.
  a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == ST_UNSUP |->
      res_r.code == CODE_NONE && res_r.branch_offset == '0 && res_r.imm_value == '0 &&
      res_r.target_reg == '0 && res_r.base_reg == '0 && res_r.sysreg_id == '0)
    else $error("unsupported result with nonzero fields");

  // Only the immediate branch forms carry an offset.
  a_offset_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.branch_offset != '0 |->
      res_r.code != CODE_NONE && 5'(res_r.code) <= 5'(CODE_BCOND))
    else $error("branch offset on a non-branch result");
`endif

endmodule

// ===== test/a64bsd_decode_checker.sv =====
// Checker for the branch/system decoder: predicts each request's decode and compares the results.
`timescale 1ns / 1ps

module a64bsd_decode_checker import a64bsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_instruction_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic [4:0]         out_instruction_code,
  input  logic signed [27:0] out_branch_offset,
  input  logic               out_is_64bit,
  input  logic [4:0]         out_target_reg,
  input  logic [4:0]         out_base_reg,
  input  logic [15:0]        out_imm_value,
  input  logic [3:0]         out_cond_code,
  input  logic [15:0]        out_sysreg_id,
  output int                 fail_count,
  output int                 n_pending
);

  // One accepted request together with the decode it must produce.
  typedef struct {
    logic [31:0] word;
    result_t     res;
  } pending_decode_t;

  pending_decode_t decode_q[$];
  int mismatch_count = 0;

  // Decode one instruction word the way the block is specified to.
  function automatic result_t predict_decode(input logic [31:0] w);
    result_t     r;
    logic [7:0]  top;
    logic [6:0]  hint;
    logic [31:0] m;
    r = '0;
    r.status = ST_UNSUP;
    top = w[31:24];
    hint = w[11:5];
    if ((top & 8'h7C) == 8'h14) begin
      // Unconditional immediate branch, with or without link.
      r.status = ST_OK;
      r.code = w[31] ? CODE_BL : CODE_B;
      r.branch_offset = {w[25:0], 2'b00};
    end else if ((top & 8'h7E) == 8'h34) begin
      // Compare and branch.
      r.status = ST_OK;
      r.code = w[24] ? CODE_CBNZ : CODE_CBZ;
      r.is_64bit = w[31];
      r.target_reg = w[4:0];
      r.branch_offset = {{7{w[23]}}, w[23:5], 2'b00};
    end else if ((top & 8'h7E) == 8'h36) begin
      // Test bit and branch; the bit number joins bit 31 and bits 23..19.
      r.status = ST_OK;
      r.code = w[24] ? CODE_TBNZ : CODE_TBZ;
      r.is_64bit = w[31];
      r.target_reg = w[4:0];
      r.imm_value = {10'd0, w[31], w[23:19]};
      r.branch_offset = {{12{w[18]}}, w[18:5], 2'b00};
    end else if (top == 8'h54) begin
      // Conditional branch; bit 4 set is not a B.cond.
      if (!w[4]) begin
        r.status = ST_OK;
        r.code = CODE_BCOND;
        r.cond_code = w[3:0];
        r.branch_offset = {{7{w[23]}}, w[23:5], 2'b00};
      end
    end else if (top == 8'hD4) begin
      // Exception generation, selected by opc and LL.
      m = w & 32'hFFE0_001F;
      case (m)
        32'hD400_0001: r.code = CODE_SVC;
        32'hD400_0002: r.code = CODE_HVC;
        32'hD400_0003: r.code = CODE_SMC;
        32'hD420_0000: r.code = CODE_BRK;
        32'hD440_0000: r.code = CODE_HLT;
        default:       r.code = CODE_NONE;
      endcase
      if (r.code != CODE_NONE) begin
        r.status = ST_OK;
        r.imm_value = w[20:5];
      end
    end else if (top == 8'hD5) begin
      if ((w & 32'hFFFF_F01F) == 32'hD503_201F) begin
        // Hint space: only the listed CRm:op2 values decode.
        r.status = ST_OK;
        case (hint)
          7'h00: r.code = CODE_NOP;
          7'h01: r.code = CODE_YIELD;
          7'h02: r.code = CODE_WFE;
          7'h03: r.code = CODE_WFI;
          7'h04: r.code = CODE_SEV;
          7'h05: r.code = CODE_SEVL;
          7'h19: r.code = CODE_PACIASP;
          7'h20, 7'h22, 7'h24, 7'h26: begin
            r.code = CODE_BTI;
            r.imm_value = {9'd0, hint - 7'h20};
          end
          default: r.status = ST_UNSUP;
        endcase
      end else if ((w & 32'hFFFF_F0FF) == 32'hD503_305F) begin
        r.status = ST_OK;
        r.code = CODE_CLREX;
        r.imm_value = {12'd0, w[11:8]};
      end else if ((w & 32'hFFFF_F0FF) == 32'hD503_309F) begin
        r.status = ST_OK;
        r.code = CODE_DSB;
        r.imm_value = {12'd0, w[11:8]};
      end else if ((w & 32'hFFFF_F0FF) == 32'hD503_30BF) begin
        r.status = ST_OK;
        r.code = CODE_DMB;
        r.imm_value = {12'd0, w[11:8]};
      end else if ((w & 32'hFFFF_F0FF) == 32'hD503_30DF) begin
        // ISB is only allocated with the full-system option.
        r.imm_value = {12'd0, w[11:8]};
        if (w[11:8] == 4'hF) begin
          r.status = ST_OK;
          r.code = CODE_ISB;
        end else begin
          r.status = ST_UNALLOC;
        end
      end else if ((w & 32'hFFF0_0000) == 32'hD510_0000 ||
                   (w & 32'hFFF0_0000) == 32'hD530_0000) begin
        r.status = ST_OK;
        r.code = w[21] ? CODE_MRS : CODE_MSR;
        r.target_reg = w[4:0];
        r.sysreg_id = w[20:5];
        r.is_64bit = 1'b1;
      end
    end else if (top == 8'hD6) begin
      // Register branches, then the two exact-word returns.
      m = w & 32'hFFFF_FC1F;
      if (m == 32'hD61F_0000 || m == 32'hD63F_0000 || m == 32'hD65F_0000) begin
        r.status = ST_OK;
        r.code = (m == 32'hD61F_0000) ? CODE_BR :
                 (m == 32'hD63F_0000) ? CODE_BLR : CODE_RET;
        r.base_reg = w[9:5];
        r.is_64bit = 1'b1;
      end else if (w == 32'hD69F_03E0) begin
        r.status = ST_OK;
        r.code = CODE_ERET;
      end else if (w == 32'hD6BF_03E0) begin
        r.status = ST_OK;
        r.code = CODE_DRPS;
      end
    end
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] word,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: word %h got %h want %h", what, word, got, want);
    mismatch_count++;
  endtask

  // Compare every field of one result with its prediction.
  task automatic compare_result(input pending_decode_t p);
    if (out_status !== p.res.status)
      report_mismatch("status", p.word, 32'(out_status), 32'(p.res.status));
    if (out_instruction_code !== p.res.code)
      report_mismatch("instruction_code", p.word, 32'(out_instruction_code),
                      32'(p.res.code));
    if (out_branch_offset !== p.res.branch_offset)
      report_mismatch("branch_offset", p.word, 32'(out_branch_offset),
                      32'(p.res.branch_offset));
    if (out_is_64bit !== p.res.is_64bit)
      report_mismatch("is_64bit", p.word, 32'(out_is_64bit), 32'(p.res.is_64bit));
    if (out_target_reg !== p.res.target_reg)
      report_mismatch("target_reg", p.word, 32'(out_target_reg), 32'(p.res.target_reg));
    if (out_base_reg !== p.res.base_reg)
      report_mismatch("base_reg", p.word, 32'(out_base_reg), 32'(p.res.base_reg));
    if (out_imm_value !== p.res.imm_value)
      report_mismatch("imm_value", p.word, 32'(out_imm_value), 32'(p.res.imm_value));
    if (out_cond_code !== p.res.cond_code)
      report_mismatch("cond_code", p.word, 32'(out_cond_code), 32'(p.res.cond_code));
    if (out_sysreg_id !== p.res.sysreg_id)
      report_mismatch("sysreg_id", p.word, 32'(out_sysreg_id), 32'(p.res.sysreg_id));
  endtask

  // Watch both channels: results are checked first, then new requests queued.
  always @(posedge clk) begin : watch_channels
    pending_decode_t p;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decode_q.size() == 0) begin
          report_mismatch("result without request", 32'h0, {30'd0, out_status}, 32'h0);
        end else begin
          p = decode_q.pop_front();
          compare_result(p);
        end
      end
      if (in_valid && !in_stall) begin
        p.word = in_instruction_word;
        p.res = predict_decode(in_instruction_word);
        decode_q.push_back(p);
      end
    end
    n_pending <= decode_q.size();
    fail_count <= mismatch_count;
  end

endmodule

// ===== test/arm64_branch_system_decoder_core_tb.sv =====
// Testbench top for the branch/system decoder: drives instruction words and gives the verdict.
`timescale 1ns / 1ps

module arm64_branch_system_decoder_core_tb;

  localparam int N_RANDOM       = 1110;
  localparam int QUIET_TAIL     = 150;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_instruction_word = 32'h0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [4:0]         out_instruction_code;
  logic signed [27:0] out_branch_offset;
  logic               out_is_64bit;
  logic [4:0]         out_target_reg;
  logic [4:0]         out_base_reg;
  logic [15:0]        out_imm_value;
  logic [3:0]         out_cond_code;
  logic [15:0]        out_sysreg_id;

  int fail_count;
  int n_pending;
  int sent_count = 0;
  bit quiet = 1'b0;

  arm64_branch_system_decoder_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_instruction_word  (in_instruction_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_instruction_code (out_instruction_code),
    .out_branch_offset    (out_branch_offset),
    .out_is_64bit         (out_is_64bit),
    .out_target_reg       (out_target_reg),
    .out_base_reg         (out_base_reg),
    .out_imm_value        (out_imm_value),
    .out_cond_code        (out_cond_code),
    .out_sysreg_id        (out_sysreg_id)
  );

  a64bsd_decode_checker decode_chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_instruction_word  (in_instruction_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_instruction_code (out_instruction_code),
    .out_branch_offset    (out_branch_offset),
    .out_is_64bit         (out_is_64bit),
    .out_target_reg       (out_target_reg),
    .out_base_reg         (out_base_reg),
    .out_imm_value        (out_imm_value),
    .out_cond_code        (out_cond_code),
    .out_sysreg_id        (out_sysreg_id),
    .fail_count           (fail_count),
    .n_pending            (n_pending)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // Directed words: field extremes, every form and the odd encodings.
  logic [31:0] directed_words[] = '{
    32'h15FF_FFFF, 32'h1600_0000, 32'h17FF_FFFF, 32'h9400_0001,
    32'hB4FF_FFFF, 32'h3500_0000, 32'h36F8_0000, 32'hB7FF_FFFF,
    32'h54FF_FFEF, 32'h5400_0010, 32'hD41F_FFE1, 32'hD400_0002,
    32'hD400_0003, 32'hD420_0000, 32'hD45F_FFE0, 32'hD400_0004,
    32'hD503_201F, 32'hD503_203F, 32'hD503_205F, 32'hD503_207F,
    32'hD503_209F, 32'hD503_20BF, 32'hD503_233F, 32'hD503_241F,
    32'hD503_24DF, 32'hD503_243F, 32'hD503_20DF, 32'hD503_3F5F,
    32'hD503_3F9F, 32'hD503_30BF, 32'hD503_3FDF, 32'hD503_30DF,
    32'hD51F_FFFF, 32'hD530_0000, 32'hD61F_03E0, 32'hD63F_0020,
    32'hD65F_03C0, 32'hD69F_03E0, 32'hD6BF_03E0, 32'hD69F_03E1,
    32'h0000_0000, 32'hFFFF_FFFF
  };

  // Build one random word, mostly well formed within a recognized group.
  function automatic logic [31:0] make_word();
    logic [31:0] w;
    logic [1:0]  pick;
    w = $urandom;
    case ($urandom_range(0, 19))
      0, 1: w[30:26] = 5'b00101;
      2, 3: w[30:25] = 6'b011010;
      4, 5: w[30:25] = 6'b011011;
      6, 7: begin
        w[31:24] = 8'h54;
        if ($urandom_range(0, 7) != 0) w[4] = 1'b0;
      end
      8, 9: begin
        w[31:24] = 8'hD4;
        if ($urandom_range(0, 5) != 0) begin
          case ($urandom_range(0, 4))
            0: {w[23:21], w[4:0]} = {3'b000, 5'd1};
            1: {w[23:21], w[4:0]} = {3'b000, 5'd2};
            2: {w[23:21], w[4:0]} = {3'b000, 5'd3};
            3: {w[23:21], w[4:0]} = {3'b001, 5'd0};
            default: {w[23:21], w[4:0]} = {3'b010, 5'd0};
          endcase
        end
      end
      10, 11: begin
        w = 32'hD503_201F;
        pick = 2'($urandom_range(0, 3));
        case (pick)
          2'd0: w[11:5] = 7'($urandom_range(0, 5));
          2'd1: w[11:5] = 7'h19;
          2'd2: w[11:5] = 7'h20 + 7'(2 * $urandom_range(0, 3));
          default: w[11:5] = 7'($urandom);
        endcase
      end
      12: begin
        case ($urandom_range(0, 3))
          0: w = 32'hD503_305F;
          1: w = 32'hD503_309F;
          2: w = 32'hD503_30BF;
          default: w = 32'hD503_30DF;
        endcase
        w[11:8] = $urandom_range(0, 1) ? 4'hF : 4'($urandom);
      end
      13, 14: w[31:20] = $urandom_range(0, 1) ? 12'hD51 : 12'hD53;
      15, 16: begin
        case ($urandom_range(0, 2))
          0: w = 32'hD61F_0000;
          1: w = 32'hD63F_0000;
          default: w = 32'hD65F_0000;
        endcase
        w[9:5] = 5'($urandom);
        if ($urandom_range(0, 4) == 0) w[14:10] = 5'($urandom);
        if ($urandom_range(0, 4) == 0) w[4:0] = 5'($urandom);
      end
      17: begin
        w = $urandom_range(0, 1) ? 32'hD69F_03E0 : 32'hD6BF_03E0;
        if ($urandom_range(0, 2) == 0) w[$urandom_range(0, 31)] ^= 1'b1;
      end
      18: w[31:24] = 8'(8'hD4 + $urandom_range(0, 2));
      default: ;
    endcase
    return w;
  endfunction

  // Offer one request and hold it until it is taken; an idle burst may come first.
  task automatic send_word(input logic [31:0] w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Reset, directed words, random words, then drain and give the verdict.
  initial begin
    int total;
    int idx;
    total = directed_words.size() + N_RANDOM;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_words[i]) send_word(directed_words[i]);
    for (idx = 0; idx < N_RANDOM; idx++) begin
      if (sent_count >= total - QUIET_TAIL) quiet = 1'b1;
      send_word(make_word());
    end
    in_valid <= 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, none near the end.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && !held && sent_count >= HOLD_AT) begin
        // Long hold-off so the block fills up and stalls its input.
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
